// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: hw/rtl/stimseq_pkg.sv
// Types and constants of the stimulus select and trigger sequencer.
// No dependencies.
package stimseq_pkg;

    localparam int unsigned DATA_BITS_DEF = 8;
    localparam int unsigned TICK_W        = 8;
    localparam int unsigned INDEX_W       = 8;
    localparam int unsigned BIT_SEL_W     = 3;
    localparam int unsigned CFG_IDX_W     = 3;
    localparam int unsigned CFG_DATA_W    = 8;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_RESET  = 3'd1,
        PH_DATA   = 3'd2,
        PH_SETTLE = 3'd3,
        PH_EDGE   = 3'd4
    } t_phase;

    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_CLEAR = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RESET_PULSE  = 3'd0,
        REG_SETTLE       = 3'd1,
        REG_TRIGGER_HOLD = 3'd2,
        REG_USE_INTERNAL = 3'd3,
        REG_INT_HIGH     = 3'd4,
        REG_INT_LOW      = 3'd5
    } t_reg_idx;

    localparam logic [TICK_W-1:0] RESET_PULSE_DEF  = 8'd10;
    localparam logic [TICK_W-1:0] SETTLE_DEF       = 8'd10;
    localparam logic [TICK_W-1:0] TRIGGER_HOLD_DEF = 8'd10;
    localparam logic              USE_INTERNAL_DEF = 1'b1;
    localparam logic [TICK_W-1:0] INT_HIGH_DEF     = 8'd26;
    localparam logic [TICK_W-1:0] INT_LOW_DEF      = 8'd4;

    typedef struct packed {
        logic [TICK_W-1:0] reset_pulse_ticks;
        logic [TICK_W-1:0] settle_ticks;
        logic [TICK_W-1:0] trigger_hold_ticks;
        logic              use_internal_clock;
        logic [TICK_W-1:0] internal_high_ticks;
        logic [TICK_W-1:0] internal_low_ticks;
    } t_cfg;

    typedef struct packed {
        logic accept;
        logic clear;
        logic run;
    } t_step_ctl;

    typedef struct packed {
        logic         select_line;
        logic         trigger_line;
        logic         armed_seen;
        logic         frame_clock_mirror;
        logic [2:0]   phase_now;
    } t_result;

endpackage

// File: hw/rtl/stimseq_in_if.sv
// Input channel of the sequencer: one tick or clear item per transfer.
// Depends on stimseq_pkg for widths.
interface stimseq_in_if import stimseq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic               enable;
    logic               arm;
    logic [INDEX_W-1:0] stim_index;
    logic               frame_clock_in;

    modport source (output valid, kind, enable, arm, stim_index, frame_clock_in,
                    input ready);
    modport sink   (input valid, kind, enable, arm, stim_index, frame_clock_in,
                    output ready);
endinterface

// File: hw/rtl/stimseq_out_if.sv
// Result channel of the sequencer: line levels and phase per transfer.
// No package dependencies.
interface stimseq_out_if;
    logic       valid;
    logic       ready;
    logic       select_line;
    logic       trigger_line;
    logic       armed_seen;
    logic       frame_clock_mirror;
    logic [2:0] phase_now;

    modport source (output valid, select_line, trigger_line, armed_seen,
                    frame_clock_mirror, phase_now, input ready);
    modport sink   (input valid, select_line, trigger_line, armed_seen,
                    frame_clock_mirror, phase_now, output ready);
endinterface

// File: hw/rtl/stimseq_cfg.sv
// Configuration register bank of the sequencer.
// Depends on stimseq_pkg.
module stimseq_cfg import stimseq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_RESET_PULSE:  n_cfg.reset_pulse_ticks   = i_cfg_data;
                REG_SETTLE:       n_cfg.settle_ticks        = i_cfg_data;
                REG_TRIGGER_HOLD: n_cfg.trigger_hold_ticks  = i_cfg_data;
                REG_USE_INTERNAL: n_cfg.use_internal_clock  = i_cfg_data[0];
                REG_INT_HIGH:     n_cfg.internal_high_ticks = i_cfg_data;
                REG_INT_LOW:      n_cfg.internal_low_ticks  = i_cfg_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_pulse_ticks   <= RESET_PULSE_DEF;
            r_cfg.settle_ticks        <= SETTLE_DEF;
            r_cfg.trigger_hold_ticks  <= TRIGGER_HOLD_DEF;
            r_cfg.use_internal_clock  <= USE_INTERNAL_DEF;
            r_cfg.internal_high_ticks <= INT_HIGH_DEF;
            r_cfg.internal_low_ticks  <= INT_LOW_DEF;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: hw/rtl/stimseq_clkgen.sv
// Internal frame clock generator: high and low phases counted in ticks.
// Depends on stimseq_pkg.
module stimseq_clkgen import stimseq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_step_ctl i_ctl,
    output logic      o_level_next
);

    logic              r_level;
    logic              n_level;
    logic [TICK_W-1:0] r_cnt;
    logic [TICK_W-1:0] n_cnt;
    logic [TICK_W-1:0] limit;
    logic [TICK_W-1:0] cnt_inc;

    always_comb begin
        limit   = r_level ? i_cfg.internal_high_ticks : i_cfg.internal_low_ticks;
        cnt_inc = r_cnt + TICK_W'(1);
        n_level = r_level;
        n_cnt   = r_cnt;
        if (i_ctl.clear) begin
            n_level = 1'b0;
            n_cnt   = '0;
        end else if (i_ctl.run) begin
            if (cnt_inc >= limit) begin
                n_cnt   = '0;
                n_level = !r_level;
            end else begin
                n_cnt   = cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b0;
            r_cnt   <= '0;
        end else if (i_ctl.accept) begin
            r_level <= n_level;
            r_cnt   <= n_cnt;
        end
    end

    assign o_level_next = n_level;

endmodule

// File: hw/rtl/stimseq_core.sv
// Select line sequencer and trigger timer, one state step per tick.
// Depends on stimseq_pkg.
module stimseq_core import stimseq_pkg::*; #(
    parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  t_step_ctl          i_ctl,
    input  logic               i_arm,
    input  logic [INDEX_W-1:0] i_stim_index,
    input  logic               i_frame_pin,
    input  logic               i_sim_level,
    output t_result            o_result
);

    t_phase             r_phase,  n_phase;
    logic [TICK_W-1:0]  r_ticks,  n_ticks;
    logic [INDEX_W-1:0] r_index,  n_index;
    logic               r_armed,  n_armed;
    logic               r_trig,   n_trig;
    logic [TICK_W-1:0]  r_rem,    n_rem;
    logic               r_sel,    n_sel;
    logic               r_prev,   n_prev;
    logic [TICK_W-1:0]  tick_inc;
    logic [BIT_SEL_W-1:0] bit_pos;
    logic               frame;

    always_comb begin
        n_phase  = r_phase;
        n_ticks  = r_ticks;
        n_index  = r_index;
        n_armed  = r_armed;
        n_trig   = r_trig;
        n_rem    = r_rem;
        n_sel    = r_sel;
        n_prev   = r_prev;
        tick_inc = r_ticks + TICK_W'(1);
        bit_pos  = BIT_SEL_W'(DATA_BITS - 1) - tick_inc[BIT_SEL_W-1:0];
        frame    = i_cfg.use_internal_clock ? i_sim_level : i_frame_pin;

        if (i_ctl.clear) begin
            n_armed = 1'b0;
            n_trig  = 1'b0;
            n_rem   = '0;
            n_phase = PH_IDLE;
            n_ticks = '0;
            n_sel   = 1'b0;
            n_prev  = i_cfg.use_internal_clock ? 1'b0 : i_frame_pin;
        end else if (!i_ctl.run) begin
            n_armed = 1'b0;
            n_trig  = 1'b0;
            n_rem   = '0;
            n_phase = PH_IDLE;
            n_ticks = '0;
            n_sel   = 1'b0;
            n_prev  = 1'b0;
        end else begin
            if (r_trig && r_rem != '0) begin
                n_rem = r_rem - TICK_W'(1);
            end
            case (r_phase)
                PH_IDLE: begin
                    if (r_armed) begin
                        n_index = i_stim_index;
                        n_ticks = '0;
                        n_sel   = 1'b1;
                        n_phase = PH_RESET;
                    end
                end
                PH_RESET: begin
                    n_ticks = tick_inc;
                    if (tick_inc >= i_cfg.reset_pulse_ticks) begin
                        n_ticks = '0;
                        n_sel   = r_index[DATA_BITS-1];
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_ticks = tick_inc;
                    if (tick_inc >= TICK_W'(DATA_BITS)) begin
                        n_sel   = 1'b0;
                        n_ticks = '0;
                        n_phase = PH_SETTLE;
                    end else begin
                        n_sel   = r_index[bit_pos];
                    end
                end
                PH_SETTLE: begin
                    if (!r_armed) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_ticks = tick_inc;
                        if (tick_inc >= i_cfg.settle_ticks) begin
                            n_phase = PH_EDGE;
                        end
                    end
                end
                default: begin
                    if (!r_armed) begin
                        n_phase = PH_IDLE;
                    end else if (r_prev && !frame) begin
                        n_trig  = 1'b1;
                        n_rem   = i_cfg.trigger_hold_ticks;
                        n_armed = 1'b0;
                        n_phase = PH_IDLE;
                    end
                end
            endcase
            n_prev = frame;
            if (n_trig && n_rem == '0) begin
                n_trig = 1'b0;
            end
            if (i_arm) begin
                n_armed = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_ticks <= '0;
            r_index <= '0;
            r_armed <= 1'b0;
            r_trig  <= 1'b0;
            r_rem   <= '0;
            r_sel   <= 1'b0;
            r_prev  <= 1'b0;
        end else if (i_ctl.accept) begin
            r_phase <= n_phase;
            r_ticks <= n_ticks;
            r_index <= n_index;
            r_armed <= n_armed;
            r_trig  <= n_trig;
            r_rem   <= n_rem;
            r_sel   <= n_sel;
            r_prev  <= n_prev;
        end
    end

    assign o_result.select_line        = n_sel;
    assign o_result.trigger_line       = n_trig;
    assign o_result.armed_seen         = r_armed;
    assign o_result.frame_clock_mirror = i_sim_level;
    assign o_result.phase_now          = n_phase;

endmodule

// File: hw/rtl/stim_select_and_trigger_sequencer.sv
// Top level of the stimulus select and trigger sequencer.
// Depends on stimseq_pkg, the channel interfaces, stimseq_cfg, stimseq_clkgen, stimseq_core.
//
// Each accepted item is one tick or a clear and yields one result in the next cycle, held in an
// output register; a new item is taken every cycle while that register is empty or being
// drained, so the block sustains one item per clock. The work per item is a single pass of
// counter compares and steps in the sequencer and the frame clock generator. Configuration
// writes take effect at the next clock edge.
module stim_select_and_trigger_sequencer import stimseq_pkg::*; #(
    parameter int unsigned DATA_BITS = DATA_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    stimseq_in_if.sink            i_item,
    stimseq_out_if.source         o_result
);

    t_cfg      cfg;
    t_step_ctl ctl;
    t_result   result_next;
    t_result   r_result;
    logic      r_out_valid;
    logic      n_out_valid;
    logic      sim_level_next;

    assign i_item.ready = !r_out_valid || o_result.ready;
    assign ctl.accept   = i_item.valid && i_item.ready;
    assign ctl.clear    = i_item.kind == KIND_CLEAR;
    assign ctl.run      = i_item.kind == KIND_TICK && i_item.enable;

    stimseq_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    stimseq_clkgen u_clkgen (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_ctl        (ctl),
        .o_level_next (sim_level_next)
    );

    stimseq_core #(
        .DATA_BITS (DATA_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_ctl        (ctl),
        .i_arm        (i_item.arm),
        .i_stim_index (i_item.stim_index),
        .i_frame_pin  (i_item.frame_clock_in),
        .i_sim_level  (sim_level_next),
        .o_result     (result_next)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (ctl.accept) begin
            n_out_valid = 1'b1;
        end else if (o_result.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.accept) begin
            r_result <= result_next;
        end
    end

    assign o_result.valid              = r_out_valid;
    assign o_result.select_line        = r_result.select_line;
    assign o_result.trigger_line       = r_result.trigger_line;
    assign o_result.armed_seen         = r_result.armed_seen;
    assign o_result.frame_clock_mirror = r_result.frame_clock_mirror;
    assign o_result.phase_now          = r_result.phase_now;

endmodule

// File: hw/rtl/stimseq_checker.sv
// Port-level checks of the sequencer, bound to the top level.
// Depends on stimseq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stimseq_checker import stimseq_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_select_line,
    input logic [2:0] i_phase_now
);

    logic in_xfer;
    logic out_stall;

    assign in_xfer   = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;

    `ASSERT_HOLDS(a_xfer_gives_result, i_clk, i_rst_n, in_xfer |=> i_out_valid, "no result after transfer")
    `ASSERT_HOLDS(a_stall_holds_valid, i_clk, i_rst_n, out_stall |=> i_out_valid, "result dropped under stall")
    `ASSERT_HOLDS(a_stall_holds_line, i_clk, i_rst_n, out_stall |=> $stable(i_select_line), "result changed under stall")
    `ASSERT_NEVER(a_quiet_select, i_clk, i_rst_n, i_out_valid && i_select_line && (i_phase_now == PH_IDLE || i_phase_now == PH_SETTLE || i_phase_now == PH_EDGE), "select high outside transmission")
    `ASSERT_NEVER(a_reset_pulse_high, i_clk, i_rst_n, i_out_valid && !i_select_line && i_phase_now == PH_RESET, "select low in reset pulse")

endmodule

bind stim_select_and_trigger_sequencer stimseq_checker u_stimseq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_select_line (o_result.select_line),
    .i_phase_now   (o_result.phase_now)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for stim_select_and_trigger_sequencer: drives tick and clear items,
// predicts all five fields of every result and compares them on each result transfer.
// Depends on stimseq_pkg, stimseq_in_if, stimseq_out_if and the block itself.
module tb;
    import stimseq_pkg::*;

    localparam int unsigned STALL_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam t_cfg CFG_RESET_VALUES = '{RESET_PULSE_DEF, SETTLE_DEF, TRIGGER_HOLD_DEF,
                                          USE_INTERNAL_DEF, INT_HIGH_DEF, INT_LOW_DEF};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    stimseq_in_if  item_if ();
    stimseq_out_if result_if ();

    stim_select_and_trigger_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_if),
        .o_result   (result_if)
    );

    // shadow copy of the sequencer
    t_cfg               shadow_cfg = CFG_RESET_VALUES;
    t_phase             seq_phase  = PH_IDLE;
    logic [TICK_W-1:0]  seq_ticks  = '0;
    logic [INDEX_W-1:0] seq_index  = '0;
    logic               seq_armed  = 1'b0;
    logic               trig_on    = 1'b0;
    logic [TICK_W-1:0]  trig_left  = '0;
    logic               sel_level  = 1'b0;
    logic               prev_frame = 1'b0;
    logic               fclk_level = 1'b0;
    logic [TICK_W-1:0]  fclk_ticks = '0;

    t_result     pending_levels[$];
    int unsigned fail_count = 0;
    int unsigned burst_left = 0;
    logic        pin_level  = 1'b0;

    function automatic t_result sequencer_step(t_kind kind, logic en, logic arm,
                                               logic [INDEX_W-1:0] idx, logic pin);
        t_result           r;
        logic              armed_at_start;
        logic              frame;
        logic [TICK_W-1:0] limit;
        armed_at_start = seq_armed;
        if (kind == KIND_CLEAR) begin
            seq_armed  = 1'b0;
            trig_on    = 1'b0;
            trig_left  = '0;
            seq_phase  = PH_IDLE;
            seq_ticks  = '0;
            sel_level  = 1'b0;
            fclk_level = 1'b0;
            fclk_ticks = '0;
            prev_frame = shadow_cfg.use_internal_clock ? 1'b0 : pin;
        end else if (!en) begin
            seq_armed  = 1'b0;
            trig_on    = 1'b0;
            trig_left  = '0;
            seq_phase  = PH_IDLE;
            seq_ticks  = '0;
            sel_level  = 1'b0;
            prev_frame = 1'b0;
        end else begin
            limit = fclk_level ? shadow_cfg.internal_high_ticks : shadow_cfg.internal_low_ticks;
            fclk_ticks = fclk_ticks + 8'd1;
            if (fclk_ticks >= limit) begin
                fclk_ticks = '0;
                fclk_level = ~fclk_level;
            end
            frame = shadow_cfg.use_internal_clock ? fclk_level : pin;
            if (trig_on && trig_left != 0)
                trig_left = trig_left - 8'd1;
            case (seq_phase)
                PH_IDLE: begin
                    if (seq_armed) begin
                        seq_index = idx;
                        seq_ticks = '0;
                        sel_level = 1'b1;
                        seq_phase = PH_RESET;
                    end
                end
                PH_RESET: begin
                    seq_ticks = seq_ticks + 8'd1;
                    if (seq_ticks >= shadow_cfg.reset_pulse_ticks) begin
                        seq_ticks = '0;
                        sel_level = seq_index[DATA_BITS_DEF - 1];
                        seq_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    seq_ticks = seq_ticks + 8'd1;
                    if (seq_ticks >= DATA_BITS_DEF) begin
                        sel_level = 1'b0;
                        seq_ticks = '0;
                        seq_phase = PH_SETTLE;
                    end else begin
                        sel_level = seq_index[DATA_BITS_DEF - 1 - seq_ticks];
                    end
                end
                PH_SETTLE: begin
                    if (!seq_armed) begin
                        seq_phase = PH_IDLE;
                    end else begin
                        seq_ticks = seq_ticks + 8'd1;
                        if (seq_ticks >= shadow_cfg.settle_ticks)
                            seq_phase = PH_EDGE;
                    end
                end
                default: begin
                    if (!seq_armed) begin
                        seq_phase = PH_IDLE;
                    end else if (prev_frame && !frame) begin
                        trig_on   = 1'b1;
                        trig_left = shadow_cfg.trigger_hold_ticks;
                        seq_armed = 1'b0;
                        seq_phase = PH_IDLE;
                    end
                end
            endcase
            prev_frame = frame;
            if (trig_on && trig_left == 0)
                trig_on = 1'b0;
            if (arm)
                seq_armed = 1'b1;
        end
        r.select_line        = sel_level;
        r.trigger_line       = trig_on;
        r.armed_seen         = armed_at_start;
        r.frame_clock_mirror = fclk_level;
        r.phase_now          = seq_phase;
        return r;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (result_if.valid && result_if.ready) begin
                got.select_line        = result_if.select_line;
                got.trigger_line       = result_if.trigger_line;
                got.armed_seen         = result_if.armed_seen;
                got.frame_clock_mirror = result_if.frame_clock_mirror;
                got.phase_now          = result_if.phase_now;
                if (pending_levels.size() == 0) begin
                    $error("result transfer with no prediction pending");
                    fail_count++;
                end else begin
                    want = pending_levels.pop_front();
                    if (got.select_line !== want.select_line) begin
                        $error("select_line: expected %0b, got %0b",
                               want.select_line, got.select_line);
                        fail_count++;
                    end
                    if (got.trigger_line !== want.trigger_line) begin
                        $error("trigger_line: expected %0b, got %0b",
                               want.trigger_line, got.trigger_line);
                        fail_count++;
                    end
                    if (got.armed_seen !== want.armed_seen) begin
                        $error("armed_seen: expected %0b, got %0b",
                               want.armed_seen, got.armed_seen);
                        fail_count++;
                    end
                    if (got.frame_clock_mirror !== want.frame_clock_mirror) begin
                        $error("frame_clock_mirror: expected %0b, got %0b",
                               want.frame_clock_mirror, got.frame_clock_mirror);
                        fail_count++;
                    end
                    if (got.phase_now !== want.phase_now) begin
                        $error("phase_now: expected %0d, got %0d",
                               want.phase_now, got.phase_now);
                        fail_count++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_RESET_PULSE:  shadow_cfg.reset_pulse_ticks   = i_cfg_data;
                    REG_SETTLE:       shadow_cfg.settle_ticks        = i_cfg_data;
                    REG_TRIGGER_HOLD: shadow_cfg.trigger_hold_ticks  = i_cfg_data;
                    REG_USE_INTERNAL: shadow_cfg.use_internal_clock  = i_cfg_data[0];
                    REG_INT_HIGH:     shadow_cfg.internal_high_ticks = i_cfg_data;
                    REG_INT_LOW:      shadow_cfg.internal_low_ticks  = i_cfg_data;
                    default: ;
                endcase
            end
            if (item_if.valid && item_if.ready)
                pending_levels.push_back(sequencer_step(t_kind'(item_if.kind), item_if.enable,
                                                        item_if.arm, item_if.stim_index,
                                                        item_if.frame_clock_in));
        end
    end

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (item_if.valid && item_if.ready) ||
                (result_if.valid && result_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : result_stall
        int unsigned run_left;
        result_if.ready <= 1'b0;
        run_left = 0;
        forever begin
            @(posedge i_clk);
            if (run_left == 0) begin
                if (result_if.ready) begin
                    result_if.ready <= 1'b0;
                    run_left = $urandom_range(1, 6);
                end else begin
                    result_if.ready <= 1'b1;
                    run_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                           : $urandom_range(1, 12);
                end
            end else begin
                run_left--;
            end
        end
    end

    task automatic send_item(t_kind kind, logic en, logic arm, logic [INDEX_W-1:0] idx,
                             logic pin);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 10);
        end
        item_if.valid          <= 1'b1;
        item_if.kind           <= kind;
        item_if.enable         <= en;
        item_if.arm            <= arm;
        item_if.stim_index     <= idx;
        item_if.frame_clock_in <= pin;
        do @(posedge i_clk); while (!item_if.ready);
        burst_left--;
    endtask

    function automatic logic next_pin();
        if ($urandom_range(0, 2) == 0)
            pin_level = ~pin_level;
        return pin_level;
    endfunction

    task automatic send_tick(logic en, logic arm);
        send_item(KIND_TICK, en, arm, 8'($urandom_range(0, 255)), next_pin());
    endtask

    task automatic wait_results_drained();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_levels.size() != 0) @(posedge i_clk);
    endtask

    task automatic apply_cfg(t_cfg c);
        logic [6:0] junk;
        junk = 7'($urandom_range(0, 127));
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_RESET_PULSE;
        i_cfg_data <= c.reset_pulse_ticks;
        @(posedge i_clk);
        i_cfg_idx  <= REG_SETTLE;
        i_cfg_data <= c.settle_ticks;
        @(posedge i_clk);
        i_cfg_idx  <= REG_TRIGGER_HOLD;
        i_cfg_data <= c.trigger_hold_ticks;
        @(posedge i_clk);
        i_cfg_idx  <= REG_USE_INTERNAL;
        i_cfg_data <= {junk, c.use_internal_clock};
        @(posedge i_clk);
        i_cfg_idx  <= REG_INT_HIGH;
        i_cfg_data <= c.internal_high_ticks;
        @(posedge i_clk);
        i_cfg_idx  <= REG_INT_LOW;
        i_cfg_data <= c.internal_low_ticks;
        @(posedge i_clk);
        i_cfg_idx  <= REG_SPARE_A;
        i_cfg_data <= 8'($urandom_range(0, 255));
        @(posedge i_clk);
        i_cfg_idx  <= REG_SPARE_B;
        i_cfg_data <= 8'($urandom_range(0, 255));
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic t_cfg random_small_cfg(logic use_int);
        t_cfg c;
        c.reset_pulse_ticks   = 8'($urandom_range(0, 6));
        c.settle_ticks        = 8'($urandom_range(0, 6));
        c.trigger_hold_ticks  = 8'($urandom_range(0, 40));
        c.use_internal_clock  = use_int;
        c.internal_high_ticks = 8'($urandom_range(0, 5));
        c.internal_low_ticks  = 8'($urandom_range(0, 5));
        return c;
    endfunction

    // mostly complete arm-and-run sequences, the rest short bursts of raw items
    task automatic run_traffic(int unsigned count);
        int unsigned sent;
        int unsigned span;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 9) < 8) begin
                span = shadow_cfg.reset_pulse_ticks + shadow_cfg.settle_ticks +
                       shadow_cfg.internal_high_ticks + shadow_cfg.internal_low_ticks + 12 +
                       $urandom_range(0, shadow_cfg.trigger_hold_ticks + 4);
                send_tick(1'b1, 1'b1);
                sent++;
                repeat (span) begin
                    send_tick($urandom_range(0, 40) != 0, $urandom_range(0, 15) == 0);
                    sent++;
                    if ($urandom_range(0, 99) == 0)
                        wait_results_drained();
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send_item(($urandom_range(0, 3) == 0) ? KIND_CLEAR : KIND_TICK,
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    sent++;
                end
            end
        end
    endtask

    task automatic test_directed();
        t_cfg zero_cfg;
        int   i;
        send_item(KIND_TICK,  1'b1, 1'b0, 8'h00, 1'b0);
        send_item(KIND_TICK,  1'b1, 1'b1, 8'hFF, 1'b1);
        send_item(KIND_TICK,  1'b1, 1'b0, 8'hFF, 1'b0);
        send_item(KIND_TICK,  1'b1, 1'b0, 8'hA5, 1'b1);
        send_item(KIND_TICK,  1'b1, 1'b0, 8'h00, 1'b0);
        send_item(KIND_TICK,  1'b0, 1'b1, 8'h5A, 1'b1);
        send_item(KIND_CLEAR, 1'b0, 1'b1, 8'hFF, 1'b1);
        wait_results_drained();
        zero_cfg = '0;
        zero_cfg.use_internal_clock = 1'b1;
        apply_cfg(zero_cfg);
        send_item(KIND_TICK, 1'b1, 1'b1, 8'hFF, 1'b0);
        for (i = 0; i < 13; i++)
            send_item(KIND_TICK, 1'b1, 1'b0, (i == 0) ? 8'hA5 : 8'h3C, i[0]);
        send_item(KIND_CLEAR, 1'b1, 1'b1, 8'h00, 1'b0);
    endtask

    task automatic test_small_lengths();
        repeat (2) begin
            wait_results_drained();
            apply_cfg(random_small_cfg(1'b1));
            run_traffic(50);
        end
    endtask

    task automatic test_external_clock();
        repeat (2) begin
            wait_results_drained();
            apply_cfg(random_small_cfg(1'b0));
            run_traffic(50);
        end
    endtask

    task automatic test_zero_lengths();
        wait_results_drained();
        apply_cfg('0);
        run_traffic(30);
    endtask

    task automatic test_longest_lengths();
        t_cfg c;
        c = '{8'hFF, 8'hFF, 8'hFF, 1'b0, 8'hFF, 8'h00};
        wait_results_drained();
        apply_cfg(c);
        send_tick(1'b1, 1'b1);
        repeat (540) send_tick(1'b1, $urandom_range(0, 199) == 0);
    endtask

    task automatic test_reset_values();
        wait_results_drained();
        apply_cfg(CFG_RESET_VALUES);
        run_traffic(50);
    endtask

    initial begin
        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_idx              <= REG_RESET_PULSE;
        i_cfg_data             <= '0;
        item_if.valid          <= 1'b0;
        item_if.kind           <= KIND_TICK;
        item_if.enable         <= 1'b0;
        item_if.arm            <= 1'b0;
        item_if.stim_index     <= '0;
        item_if.frame_clock_in <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_small_lengths();
        test_external_clock();
        test_zero_lengths();
        test_longest_lengths();
        test_reset_values();

        wait_results_drained();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0 && pending_levels.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: stim_select_and_trigger_sequencer.f
+incdir+hw/rtl
hw/rtl/stimseq_pkg.sv
hw/rtl/stimseq_in_if.sv
hw/rtl/stimseq_out_if.sv
hw/rtl/stimseq_cfg.sv
hw/rtl/stimseq_clkgen.sv
hw/rtl/stimseq_core.sv
hw/rtl/stim_select_and_trigger_sequencer.sv
hw/rtl/stimseq_checker.sv
bench/tb.sv
